// File: design/fep_pkg.sv
// Shared types, sizes and codes for the FIFO page eviction block with pinning.
`timescale 1ns / 1ps

package fep_pkg;

    // Table size and derived widths
    localparam int DEPTH   = 64;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;  // entry index
    localparam int CW      = $clog2(DEPTH + 1);                // entry count
    localparam int ID_W    = 32;
    localparam int ENTRY_W = 7;                                // result count field

    // Action codes
    localparam logic [2:0] ACT_KNOW     = 3'd0;
    localparam logic [2:0] ACT_FORGET   = 3'd1;
    localparam logic [2:0] ACT_USED     = 3'd2;
    localparam logic [2:0] ACT_PRESERVE = 3'd3;
    localparam logic [2:0] ACT_RELEASE  = 3'd4;
    localparam logic [2:0] ACT_EVICT    = 3'd5;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_NONE    = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [2:0]      action;
        logic [ID_W-1:0] page_id;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [ID_W-1:0]    victim_id;
        logic [ENTRY_W-1:0] entry_count;
    } rsp_t;

    // One table entry as stored in the RAM
    typedef struct packed {
        logic            pinned;
        logic [ID_W-1:0] id;
    } entry_t;

    localparam int ENTRY_BITS = $bits(entry_t);

endpackage

// File: design/fep_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module fep_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/fep_cmp.sv
// Shared entry compare unit: id match, or unpinned test for victim search.
`timescale 1ns / 1ps

module fep_cmp
    import fep_pkg::*;
(
    input  logic            find_free,
    input  entry_t          entry,
    input  logic [ID_W-1:0] key,
    output logic            hit
);

    assign hit = find_free ? !entry.pinned : (entry.id == key);

endmodule

// File: design/fifo_eviction_with_pinning.sv
// Top level: FIFO page replacement list with pin flags, scanned by a sequencer.
`timescale 1ns / 1ps

//  channel | direction | handshake        | payload
//  --------+-----------+------------------+----------------------------------
//  req     | in        | req_valid/stall  | req_t: action, page_id
//  rsp     | out       | rsp_valid/stall  | rsp_t: status, victim_id, entry_count
//
//  One item at a time; req_stall is high while an item is in work. A scan reads one
//  entry a cycle through the RAM's single read port and the shared compare unit.
//  Forget moves the younger entries down one a cycle right after the hit. Used,
//  spare codes and an empty list skip the scan. Reset clears count and flags;
//  entries above the count are never read. A result waits in the output register
//  while rsp is stalled.

module fifo_eviction_with_pinning
    import fep_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } state_t;

    state_t          state_reg, state_next;
    logic [2:0]      act_reg, act_next;
    logic [ID_W-1:0] id_reg, id_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [CW-1:0]   rd_idx_reg, rd_idx_next;     // next entry to read
    logic            ck_valid_reg, ck_valid_next; // RAM data is valid this cycle
    logic [AW-1:0]   ck_idx_reg, ck_idx_next;     // index of RAM data
    logic [1:0]      status_reg, status_next;
    logic [ID_W-1:0] victim_reg, victim_next;
    logic            rsp_valid_reg, rsp_valid_next;
    rsp_t            rsp_reg, rsp_next;

    // RAM port signals
    logic            we;
    logic [AW-1:0]   waddr;
    entry_t          wdata;
    logic [AW-1:0]   raddr;
    logic [ENTRY_BITS-1:0] rdata_raw;
    entry_t          rdata;

    logic            hit;
    logic            last;
    logic [CW-1:0]   cnt_m1;

    assign rdata  = entry_t'(rdata_raw);
    assign raddr  = rd_idx_reg[AW-1:0];
    assign cnt_m1 = cnt_reg - CW'(1);
    assign last   = (CW'(ck_idx_reg) == cnt_m1);

    fep_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_raw)
    );

    fep_cmp u_cmp (
        .find_free (act_reg == ACT_EVICT),
        .entry     (rdata),
        .key       (id_reg),
        .hit       (hit)
    );

    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        id_next        = id_reg;
        cnt_next       = cnt_reg;
        rd_idx_next    = rd_idx_reg;
        ck_valid_next  = 1'b0;
        ck_idx_next    = ck_idx_reg;
        status_next    = status_reg;
        victim_next    = victim_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        we             = 1'b0;
        waddr          = ck_idx_reg;
        wdata          = '0;

        // Read issue for scan and shift passes, one entry a cycle
        if ((state_reg == S_SCAN || state_reg == S_SHIFT) && rd_idx_reg < cnt_reg)
        begin
            rd_idx_next   = rd_idx_reg + CW'(1);
            ck_valid_next = 1'b1;
            ck_idx_next   = rd_idx_reg[AW-1:0];
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    act_next    = req.action;
                    id_next     = req.page_id;
                    status_next = ST_OK;
                    victim_next = '0;
                    state_next  = S_DONE;
                    if (req.action inside {ACT_KNOW, ACT_FORGET, ACT_PRESERVE,
                                           ACT_RELEASE, ACT_EVICT})
                    begin
                        if (cnt_reg == '0)
                        begin
                            // Empty list: know appends at once, others fail
                            if (req.action == ACT_KNOW)
                            begin
                                we       = 1'b1;
                                waddr    = '0;
                                wdata    = '{pinned: 1'b0, id: req.page_id};
                                cnt_next = CW'(1);
                            end
                            else if (req.action == ACT_EVICT)
                            begin
                                status_next = ST_NONE;
                            end
                            else
                            begin
                                status_next = ST_UNKNOWN;
                            end
                        end
                        else
                        begin
                            state_next    = S_SCAN;
                            rd_idx_next   = '0;
                            ck_valid_next = 1'b0;
                        end
                    end
                end
            end

            S_SCAN:
            begin
                if (ck_valid_reg)
                begin
                    if (hit)
                    begin
                        state_next = S_DONE;
                        case (act_reg)
                            ACT_FORGET:
                            begin
                                if (last)
                                begin
                                    cnt_next = cnt_m1;
                                end
                                else
                                begin
                                    // Move younger entries down over the gap
                                    state_next    = S_SHIFT;
                                    rd_idx_next   = CW'(ck_idx_reg) + CW'(1);
                                    ck_valid_next = 1'b0;
                                end
                            end
                            ACT_PRESERVE, ACT_RELEASE:
                            begin
                                we    = 1'b1;
                                waddr = ck_idx_reg;
                                wdata = '{pinned: (act_reg == ACT_PRESERVE), id: rdata.id};
                            end
                            ACT_EVICT:
                            begin
                                victim_next = rdata.id;
                            end
                            default:
                            begin
                                // know of a listed page: no change
                            end
                        endcase
                    end
                    else if (last)
                    begin
                        state_next = S_DONE;
                        case (act_reg)
                            ACT_KNOW:
                            begin
                                if (cnt_reg == CW'(DEPTH))
                                begin
                                    status_next = ST_FULL;
                                end
                                else
                                begin
                                    we       = 1'b1;
                                    waddr    = AW'(cnt_reg);
                                    wdata    = '{pinned: 1'b0, id: id_reg};
                                    cnt_next = cnt_reg + CW'(1);
                                end
                            end
                            ACT_EVICT:
                            begin
                                status_next = ST_NONE;
                            end
                            default:
                            begin
                                status_next = ST_UNKNOWN;
                            end
                        endcase
                    end
                end
            end

            S_SHIFT:
            begin
                if (ck_valid_reg)
                begin
                    we    = 1'b1;
                    waddr = ck_idx_reg - AW'(1);
                    wdata = rdata;
                    if (last)
                    begin
                        cnt_next   = cnt_m1;
                        state_next = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next = '{status:      status_reg,
                                 victim_id:   victim_reg,
                                 entry_count: ENTRY_W'(cnt_reg)};
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            ck_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ck_valid_reg  <= ck_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        id_reg     <= id_next;
        rd_idx_reg <= rd_idx_next;
        ck_idx_reg <= ck_idx_next;
        status_reg <= status_next;
        victim_reg <= victim_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("entry count above table size");

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg == S_DONE))
        else $error("result loaded outside done state");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == ST_FULL) |-> (rsp.entry_count == ENTRY_W'(DEPTH)))
        else $error("table full reported below capacity");

    a_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status != ST_OK) |-> (rsp.victim_id == '0))
        else $error("victim id set on failed action");
`endif

endmodule

// File: sim/tb.sv
// Self-checking testbench for the FIFO page eviction list with pin flags.
`timescale 1ns / 1ps

module tb;
    import fep_pkg::*;

    // Action codes the block must ignore (status ok, list unchanged)
    localparam logic [2:0] ACT_SPARE6 = 3'd6;
    localparam logic [2:0] ACT_SPARE7 = 3'd7;

    // Stimulus mixes for the random part
    localparam int MIX_FILL  = 0;   // mostly know: drives the list to full
    localparam int MIX_DRAIN = 1;   // mostly forget: empties the list
    localparam int MIX_PIN   = 2;   // mostly preserve: all-pinned evict misses
    localparam int MIX_BLEND = 3;

    localparam int POOL_SIZE    = 72;   // a bit over DEPTH so the table can overflow
    localparam int RANDOM_ITEMS = 1026;
    localparam int DRAIN_CYCLES = 200;  // quiet wait after the last result

    // Per-mix weights: know, forget, used, preserve, release, evict, spare codes
    int unsigned action_mix [4][7] = '{
        '{70,  5, 3,  8,  4,  8, 2},
        '{10, 50, 3, 10,  7, 18, 2},
        '{20, 10, 3, 35,  5, 25, 2},
        '{30, 20, 5, 15, 10, 18, 2}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    fifo_eviction_with_pinning dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #2 clk = ~clk;

    // ---------------------------------------------------------------------
    // Predictor: our own copy of the page list, oldest entry at index 0.
    // ---------------------------------------------------------------------
    logic [ID_W-1:0] listed_ids [DEPTH];
    logic            listed_pinned [DEPTH];
    int unsigned     listed_count = 0;

    // Applies one item to the shadow list and returns the result it should give.
    function automatic rsp_t page_list_apply(req_t r);
        rsp_t        o;
        int unsigned pos;
        logic        found;
        o.status    = ST_OK;
        o.victim_id = '0;
        // position of the page, or listed_count when it is not listed
        pos = listed_count;
        for (int unsigned i = 0; i < listed_count; i++)
            if (pos == listed_count && listed_ids[i] == r.page_id)
                pos = i;
        case (r.action)
            ACT_KNOW:
                if (pos == listed_count)
                begin
                    if (listed_count >= DEPTH)
                        o.status = ST_FULL;
                    else
                    begin
                        listed_ids[listed_count]    = r.page_id;
                        listed_pinned[listed_count] = 1'b0;
                        listed_count++;
                    end
                end
            ACT_FORGET:
                if (pos == listed_count)
                    o.status = ST_UNKNOWN;
                else
                begin
                    // younger entries slide down over the hole
                    for (int unsigned i = pos; i + 1 < listed_count; i++)
                    begin
                        listed_ids[i]    = listed_ids[i + 1];
                        listed_pinned[i] = listed_pinned[i + 1];
                    end
                    listed_count--;
                end
            ACT_PRESERVE, ACT_RELEASE:
                if (pos == listed_count)
                    o.status = ST_UNKNOWN;
                else
                    listed_pinned[pos] = (r.action == ACT_PRESERVE);
            ACT_EVICT:
            begin
                // oldest unpinned entry wins; none means nothing evictable
                o.status = ST_NONE;
                found = 1'b0;
                for (int unsigned i = 0; i < listed_count; i++)
                    if (!found && !listed_pinned[i])
                    begin
                        found       = 1'b1;
                        o.victim_id = listed_ids[i];
                        o.status    = ST_OK;
                    end
            end
            default: ;  // used and spare codes change nothing
        endcase
        o.entry_count = ENTRY_W'(listed_count);
        return o;
    endfunction

    // ---------------------------------------------------------------------
    // Traffic shaping, driven by the sequencing block below
    // ---------------------------------------------------------------------
    int unsigned send_idle_pct = 10;
    int unsigned recv_idle_pct = 51;
    int unsigned hold_requests = 0;   // bumped to ask for one long rsp hold-off
    int unsigned hold_served = 0;
    int unsigned hold_left = 0;

    req_t        pending_items [$];
    rsp_t        expected_rsps [$];
    int unsigned items_taken = 0;
    int unsigned error_count = 0;
    logic        req_taken = 1'b0;    // req was accepted at the last rising edge

    // Sender: pops a new item only once the one on the port has been taken,
    // so a stalled item never changes.
    always @(negedge clk)
    begin
        if (!rst_n)
            req_valid <= 1'b0;
        else if (!req_valid || req_taken)
        begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                req       <= pending_items.pop_front();
                req_valid <= 1'b1;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // Receiver: random stalls, or a long hold-off counted down here when asked.
    // The hold-off lets the block finish one item into its output register and
    // then back up onto the request side while the sender keeps offering.
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served <= hold_requests;
            hold_left   <= 300;
            rsp_stall   <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Monitor: predicts on every accepted item, checks every accepted result.
    always @(posedge clk)
    begin : watch_ports
        rsp_t want;
        if (!rst_n)
            req_taken <= 1'b0;
        else
        begin
            req_taken <= req_valid && !req_stall;
            if (req_valid && !req_stall)
            begin
                expected_rsps = {expected_rsps, page_list_apply(req)};
                items_taken <= items_taken + 1;
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $error("unexpected result: status %0d victim_id %h entry_count %0d",
                           rsp.status, rsp.victim_id, rsp.entry_count);
                    error_count = error_count + 1;
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                        error_count = error_count + 1;
                    end
                    if (rsp.victim_id !== want.victim_id)
                    begin
                        $error("victim_id: expected %h, got %h",
                               want.victim_id, rsp.victim_id);
                        error_count = error_count + 1;
                    end
                    if (rsp.entry_count !== want.entry_count)
                    begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, rsp.entry_count);
                        error_count = error_count + 1;
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    logic [ID_W-1:0] id_pool [POOL_SIZE];

    function automatic req_t page_req(logic [2:0] act, logic [ID_W-1:0] id);
        req_t r;
        r.action  = act;
        r.page_id = id;
        return r;
    endfunction

    // Appends one item to the tail of the pending queue.
    task automatic queue_item(req_t r);
        pending_items = {pending_items, r};
    endtask

    // Random item under one mix; ids mostly from the pool so they hit listed
    // pages, with some fresh 32-bit ids that are almost never listed.
    function automatic req_t random_page_req(int mix);
        req_t        r;
        int unsigned pick;
        int unsigned slot;
        pick = $urandom_range(0, 99);
        slot = 0;
        while (slot < 6 && pick >= action_mix[mix][slot])
        begin
            pick -= action_mix[mix][slot];
            slot++;
        end
        case (slot)
            0:       r.action = ACT_KNOW;
            1:       r.action = ACT_FORGET;
            2:       r.action = ACT_USED;
            3:       r.action = ACT_PRESERVE;
            4:       r.action = ACT_RELEASE;
            5:       r.action = ACT_EVICT;
            default: r.action = ($urandom_range(0, 1) != 0) ? ACT_SPARE6 : ACT_SPARE7;
        endcase
        if ($urandom_range(0, 9) == 0)
            r.page_id = $urandom();
        else
            r.page_id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
        return r;
    endfunction

    initial
    begin
        int unsigned random_pushed;
        int unsigned block_len;
        int          mix;

        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            id_pool[i] = $urandom();

        // Directed: empty-list misses, ignored codes, boundary ids, a duplicate
        // know, pin/unpin walking the evict pointer, every-entry-pinned miss,
        // and forgets at the head and the tail.
        queue_item(page_req(ACT_EVICT, 32'h1234_5678));  // empty list
        queue_item(page_req(ACT_FORGET, 32'h0000_0001));
        queue_item(page_req(ACT_PRESERVE, 32'h8000_0000));
        queue_item(page_req(ACT_RELEASE, 32'h7FFF_FFFF));
        queue_item(page_req(ACT_USED, 32'hDEAD_BEEF));   // unlisted: still ok
        queue_item(page_req(ACT_SPARE6, '1));
        queue_item(page_req(ACT_SPARE7, '0));
        queue_item(page_req(ACT_KNOW, '0));
        queue_item(page_req(ACT_KNOW, '1));
        queue_item(page_req(ACT_KNOW, '0));              // already listed
        queue_item(page_req(ACT_KNOW, 32'h5555_5555));
        queue_item(page_req(ACT_KNOW, 32'hAAAA_AAAA));
        queue_item(page_req(ACT_PRESERVE, '0));
        queue_item(page_req(ACT_EVICT, '0));
        queue_item(page_req(ACT_PRESERVE, '1));
        queue_item(page_req(ACT_PRESERVE, 32'h5555_5555));
        queue_item(page_req(ACT_PRESERVE, 32'hAAAA_AAAA));
        queue_item(page_req(ACT_EVICT, 32'hFFFF_0000));  // all pinned
        queue_item(page_req(ACT_RELEASE, '1));
        queue_item(page_req(ACT_EVICT, '0));
        queue_item(page_req(ACT_FORGET, '0));            // head
        queue_item(page_req(ACT_FORGET, 32'hAAAA_AAAA)); // tail
        queue_item(page_req(ACT_FORGET, 32'h5555_5555));
        queue_item(page_req(ACT_FORGET, '1));            // back to empty

        // Random: open with the whole pool known in order so the table is sure
        // to overflow, then blocks of biased mixes.
        random_pushed = 0;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            queue_item(page_req(ACT_KNOW, id_pool[i]));
            random_pushed++;
        end
        while (random_pushed < RANDOM_ITEMS)
        begin
            mix = $urandom_range(MIX_FILL, MIX_BLEND);
            block_len = $urandom_range(20, 60);
            for (int unsigned i = 0; i < block_len && random_pushed < RANDOM_ITEMS; i++)
            begin
                queue_item(random_page_req(mix));
                random_pushed++;
            end
        end

        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Idling phases, keyed to items accepted so far
        while (items_taken < 350)
            @(posedge clk);
        send_idle_pct = 51;
        recv_idle_pct = 10;
        while (items_taken < 700)
            @(posedge clk);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (items_taken < 850)
            @(posedge clk);
        hold_requests = hold_requests + 1;

        // Drain: all items taken, then all results back, then a quiet stretch
        // so any stray extra result still gets flagged.
        while (pending_items.size() != 0 || req_valid)
            @(posedge clk);
        while (expected_rsps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_rsps.size() != 0)
            $error("%0d expected results never arrived", expected_rsps.size());
        if (error_count == 0 && expected_rsps.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // Watchdog, well past the slowest legal run
    initial
    begin
        #2_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule
